/* design/lsps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsps_pkg: shared types and constants of the line sensor PID steering core
// Field widths, register indexes and register reset values.
// ----------------------------------------------------------------------------
package lsps_pkg;

	localparam int PATTERN_W = 8;
	localparam int DRIVE_W   = 16;
	localparam int ERROR_W   = 4;
	localparam int INTEG_W   = 11;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 15;
	localparam int KP_W      = 10;
	localparam int KD_W      = 8;
	localparam int ILIM_W    = 10;
	localparam int OLIM_W    = 15;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_PROP_GAIN      = 2'd0;
	localparam cfg_idx_t CFG_DERIV_GAIN     = 2'd1;
	localparam cfg_idx_t CFG_INTEGRAL_LIMIT = 2'd2;
	localparam cfg_idx_t CFG_OUTPUT_LIMIT   = 2'd3;

	localparam logic [KP_W-1:0]   KP_RESET   = 10'd250;
	localparam logic [KD_W-1:0]   KD_RESET   = 8'd2;
	localparam logic [ILIM_W-1:0] ILIM_RESET = 10'd500;
	localparam logic [OLIM_W-1:0] OLIM_RESET = 15'd5000;

	// Reciprocal of five for magnitudes below 1024: q = (m * 205) >> 10
	localparam logic [7:0] RECIP5      = 8'd205;
	localparam int         RECIP5_SHIFT = 10;

	typedef logic signed [ERROR_W-1:0] error_t;
	typedef logic signed [INTEG_W-1:0] integ_t;
	typedef logic signed [DRIVE_W-1:0] drive_t;

endpackage

/* design/lsps_sensor_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsps_sensor_if: sensor sample channel
// Valid/ready channel carrying one sample of the eight-sensor bar.
// ----------------------------------------------------------------------------
interface lsps_sensor_if import lsps_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [PATTERN_W-1:0] sensor_pattern;
	logic                 sample_valid;

	modport source (output valid, output sensor_pattern, output sample_valid, input ready);
	modport sink   (input valid, input sensor_pattern, input sample_valid, output ready);
endinterface

/* design/lsps_drive_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsps_drive_if: steering drive channel
// Valid/ready channel carrying one steering result.
// ----------------------------------------------------------------------------
interface lsps_drive_if import lsps_pkg::*; ();
	logic   valid;
	logic   ready;
	drive_t steering_drive;
	error_t line_error;

	modport source (output valid, output steering_drive, output line_error, input ready);
	modport sink   (input valid, input steering_drive, input line_error, output ready);
endinterface

/* design/line_sensor_pid_steering_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_sensor_pid_steering_core: line sensor decode and positional PID
// Decodes each good sensor sample into a position error, keeps a clamped
// error integral and produces a saturated PID steering drive.
// ----------------------------------------------------------------------------
//
//  channel   dir  transfer when         payload
//  --------  ---  --------------------  ------------------------------------
//  sensor    in   valid && ready        sensor_pattern[7:0], sample_valid
//  drive     out  valid && ready        steering_drive[15:0], line_error[3:0]
//  cfg_*     in   cfg_we                cfg_index[1:0], cfg_wdata[14:0]
//
//  Three register stages: input (_s1), decode/integral (_s2), result (_q).
//  A good sample passes _s1 and _s2 into _q, where it shows up on the drive
//  channel; one sample is taken every cycle while the drive side keeps up.
//  A sample with sample_valid low is taken and dropped, no result.
//  Stalls: each stage advances when the one after it is empty or advancing,
//  so bubbles fill up before sensor.ready drops.
//  Reset (arst_n low) clears all valid bits, the error history, the
//  integral, and loads the register reset values.
//
module line_sensor_pid_steering_core import lsps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	lsps_sensor_if.sink          sensor,
	lsps_drive_if.source         drive,
	input  logic                 cfg_we,
	input  cfg_idx_t             cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata
);

	// Configuration registers
	logic [KP_W-1:0]   kp_q;
	logic [KD_W-1:0]   kd_q;
	logic [ILIM_W-1:0] ilim_q;
	logic [OLIM_W-1:0] olim_q;

	// Controller state
	error_t prev_err_q;
	integ_t integ_q;

	// Pipeline
	logic                 v_s1;
	logic [PATTERN_W-1:0] pat_s1;
	logic                 v_s2;
	error_t               err_s2;
	logic signed [4:0]    derr_s2;
	integ_t               integ_s2;
	logic                 out_v_q;
	drive_t               drive_q;
	error_t               err_q;

	logic rdy_out, rdy_s2, rdy_s1;
	logic adv_s1;

	// Stage 1 decode
	error_t               e_c;
	logic signed [11:0]   isum_c;
	logic signed [11:0]   ilim_c;
	integ_t               integ_c;

	// Stage 2 arithmetic
	logic signed [15:0]   pe_c, de_c, qi_c, ri_c, b_c, q_c, olim_c, drv_c;
	logic [9:0]           mag_c;
	logic [17:0]          prod_c;
	logic [7:0]           qm_c;

	// --------------------------------------------------------------------
	// Handshake: ready ripples back from the drive side
	// --------------------------------------------------------------------
	assign rdy_out      = !out_v_q || drive.ready;
	assign rdy_s2       = !v_s2 || rdy_out;
	assign rdy_s1       = !v_s1 || rdy_s2;
	assign sensor.ready = rdy_s1;
	assign adv_s1       = v_s1 && rdy_s2;

	// --------------------------------------------------------------------
	// Configuration writes
	// --------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= KP_RESET;
			kd_q   <= KD_RESET;
			ilim_q <= ILIM_RESET;
			olim_q <= OLIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PROP_GAIN:      kp_q   <= cfg_wdata[KP_W-1:0];
				CFG_DERIV_GAIN:     kd_q   <= cfg_wdata[KD_W-1:0];
				CFG_INTEGRAL_LIMIT: ilim_q <= cfg_wdata[ILIM_W-1:0];
				CFG_OUTPUT_LIMIT:   olim_q <= cfg_wdata[OLIM_W-1:0];
			endcase
		end
	end

	// --------------------------------------------------------------------
	// Input register: keep only good samples
	// --------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= sensor.valid && sensor.sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && sensor.valid) begin
			pat_s1 <= sensor.sensor_pattern;
		end
	end

	// --------------------------------------------------------------------
	// Error decode, first match wins; no match keeps the last error
	// --------------------------------------------------------------------
	always_comb begin
		priority if (!pat_s1[4] || !pat_s1[3]) e_c = 4'sd0;
		else if (pat_s1 == 8'hDF)              e_c = -4'sd2;
		else if (pat_s1 == 8'h9F)              e_c = -4'sd3;
		else if (pat_s1 == 8'hFB)              e_c = 4'sd2;
		else if (pat_s1 == 8'hF9)              e_c = 4'sd3;
		else if (!pat_s1[5])                   e_c = -4'sd1;
		else if (!pat_s1[6])                   e_c = -4'sd2;
		else if (!pat_s1[1])                   e_c = 4'sd4;
		else                                   e_c = prev_err_q;
	end

	// Integral: add the error, clamp to +-integral_limit
	always_comb begin
		isum_c = 12'(integ_q) + 12'(e_c);
		ilim_c = $signed({2'b00, ilim_q});
		if (isum_c > ilim_c) begin
			integ_c = INTEG_W'(ilim_c);
		end else if (isum_c < -ilim_c) begin
			integ_c = INTEG_W'(-ilim_c);
		end else begin
			integ_c = INTEG_W'(isum_c);
		end
	end

	// State advances together with the item leaving stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			integ_q    <= '0;
			v_s2       <= 1'b0;
		end else begin
			if (adv_s1) begin
				prev_err_q <= e_c;
				integ_q    <= integ_c;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			err_s2   <= e_c;
			derr_s2  <= 5'(e_c) - 5'(prev_err_q);
			integ_s2 <= integ_c;
		end
	end

	// --------------------------------------------------------------------
	// Drive: trunc((5*kp*e + I + 5*kd*d) / 5) = kp*e + kd*d + I/5, with a
	// one-step fixup when the remainder of I opposes the sign of the sum
	// --------------------------------------------------------------------
	always_comb begin
		pe_c   = $signed({6'b0, kp_q}) * 16'(err_s2);
		de_c   = $signed({8'b0, kd_q}) * 16'(derr_s2);
		mag_c  = integ_s2[INTEG_W-1] ? 10'(-integ_s2) : 10'(integ_s2);
		prod_c = 18'(mag_c) * 18'(RECIP5);
		qm_c   = prod_c[RECIP5_SHIFT +: 8];
		qi_c   = integ_s2[INTEG_W-1] ? -$signed({8'b0, qm_c}) : $signed({8'b0, qm_c});
		ri_c   = 16'(integ_s2) - ((qi_c <<< 2) + qi_c);
		b_c    = pe_c + de_c + qi_c;
		priority if (b_c > 16'sd0 && ri_c < 16'sd0) q_c = b_c - 16'sd1;
		else if (b_c < 16'sd0 && ri_c > 16'sd0)     q_c = b_c + 16'sd1;
		else                                        q_c = b_c;
		olim_c = $signed({1'b0, olim_q});
		if (q_c > olim_c) begin
			drv_c = olim_c;
		end else if (q_c < -olim_c) begin
			drv_c = -olim_c;
		end else begin
			drv_c = q_c;
		end
	end

	// --------------------------------------------------------------------
	// Result register: hold while the drive side stalls
	// --------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (rdy_out) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && v_s2) begin
			drive_q <= drv_c;
			err_q   <= err_s2;
		end
	end

	assign drive.valid          = out_v_q;
	assign drive.steering_drive = drive_q;
	assign drive.line_error     = err_q;

endmodule

/* design/lsps_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsps_checker: port-level checks of the steering core
// Watches the sensor and drive channels and flags illegal behavior.
// ----------------------------------------------------------------------------
module lsps_checker import lsps_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   in_ready,
	input logic   out_valid,
	input logic   out_ready,
	input drive_t out_drive,
	input error_t out_error
);

	// A stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_drive) && $stable(out_error))
		else $error("drive payload changed while stalled");

	// The sensor side is never blocked unless the drive side is
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("sensor not ready while drive side free");

	// Error stays in -4..4
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_error >= -4'sd4 && out_error <= 4'sd4))
		else $error("line error out of range");

	// Drive is symmetric-saturated, never the most negative code
	a_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_drive != 16'sh8000)
		else $error("steering drive out of range");

endmodule

bind line_sensor_pid_steering_core lsps_checker u_lsps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (sensor.ready),
	.out_valid (drive.valid),
	.out_ready (drive.ready),
	.out_drive (drive.steering_drive),
	.out_error (drive.line_error)
);

/* verif/tb_line_sensor_pid_steering_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_sensor_pid_steering_core: self-checking bench for the steering core
// Feeds sensor samples over the valid/ready channel and predicts every
// steering result with a local decode + PID model. Idle bursts on both sides
// and directed, phased and random stimulus under changing gains and limits.
// ----------------------------------------------------------------------------
module tb_line_sensor_pid_steering_core import lsps_pkg::*; ();

	// Generous bound on the whole run; a correct run needs a small fraction.
	localparam int CYCLE_LIMIT  = 300000;
	// Pipeline is three stages deep; give it a few more before touching regs.
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_COUNT   = 8;
	localparam int PHASE_GOOD    = 195;
	localparam int MAX_REPORTS   = 10;

	// Patterns that hit the decoder's interesting branches: one sensor lit at
	// each position, the fixed two-sensor codes, center and edge pairs and no line.
	localparam logic [7:0] FEATURED [16] = '{
		8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F,
		8'h9F, 8'hF9, 8'hE7, 8'hCF, 8'hF3, 8'hFC, 8'h3F, 8'hFF
	};

	typedef struct packed {
		logic [PATTERN_W-1:0] pattern;
		logic                 good;
	} sample_t;

	typedef struct packed {
		drive_t drive;
		error_t err;
	} steer_t;

	typedef struct {
		logic [KP_W-1:0]   kp;
		logic [KD_W-1:0]   kd;
		logic [ILIM_W-1:0] ilim;
		logic [OLIM_W-1:0] olim;
	} tuning_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	cfg_idx_t             cfg_index;
	logic [CFG_DAT_W-1:0] cfg_wdata;

	lsps_sensor_if sensor_ch ();
	lsps_drive_if  drive_ch ();

	line_sensor_pid_steering_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sensor    (sensor_ch),
		.drive     (drive_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Stimulus and scoreboard state
	sample_t     sample_q[$];   // samples waiting to be driven
	steer_t      steer_q[$];    // predicted results, oldest first
	logic        sample_live;   // a sample sits on the channel, not yet transferred
	int unsigned idle_odds;     // 1-in-N chance of an idle burst, 0 disables idling
	int unsigned feed_gap;
	int unsigned hold_gap;
	int unsigned cycle_count;
	int unsigned fail_count;

	// Local copy of the core's registers and PID history
	tuning_t tuning;
	error_t  last_err;
	integ_t  integ_sum;

	// ------------------------------------------------------------------------
	// Clock: 8 ns period
	// ------------------------------------------------------------------------
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Line position decode: center pair first, then the fixed two-sensor
	// codes, then single sensors outward. No match keeps the last error.
	// ------------------------------------------------------------------------
	function automatic error_t decode_line(logic [7:0] pat, error_t keep);
		if (!pat[4] || !pat[3])
			return 4'sd0;
		case (pat)
			8'hDF: return -4'sd2;
			8'h9F: return -4'sd3;
			8'hFB: return 4'sd2;
			8'hF9: return 4'sd3;
			default: ;
		endcase
		if (!pat[5])
			return -4'sd1;
		if (!pat[6])
			return -4'sd2;
		if (!pat[1])
			return 4'sd4;
		return keep;
	endfunction

	function automatic int clamp_sym(int v, int lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// One good sample through the PID: scaled sum carries the integral at
	// full weight so that dividing by five gives exact KI = 1/5.
	function automatic steer_t advance_steering(logic [7:0] pat);
		steer_t res;
		error_t e;
		int     integ;
		int     scaled;
		int     drv;
		e      = decode_line(pat, last_err);
		integ  = clamp_sym(int'(integ_sum) + int'(e), int'(tuning.ilim));
		scaled = 5 * int'(tuning.kp) * int'(e) + integ
		       + 5 * int'(tuning.kd) * (int'(e) - int'(last_err));
		// int division truncates toward zero, as the core must
		drv       = clamp_sym(scaled / 5, int'(tuning.olim));
		integ_sum = integ_t'(integ);
		last_err  = e;
		res.drive = drive_t'(drv);
		res.err   = e;
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Sensor driver: change inputs on the falling edge. Hold a sample until
	// its transfer; between samples insert idle bursts at random.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		sample_t s;
		if (sample_live) begin
			// hold valid and payload until the core takes them
		end else if (feed_gap > 0) begin
			feed_gap--;
			sensor_ch.valid <= 1'b0;
		end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			feed_gap = $urandom_range(0, 3);
			sensor_ch.valid <= 1'b0;
		end else if (sample_q.size() > 0) begin
			s           = sample_q.pop_front();
			sample_live = 1'b1;
			sensor_ch.valid          <= 1'b1;
			sensor_ch.sensor_pattern <= s.pattern;
			sensor_ch.sample_valid   <= s.good;
		end else begin
			sensor_ch.valid <= 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// Drive side back-pressure: drop ready in random bursts.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_gap > 0) begin
			hold_gap--;
			drive_ch.ready <= 1'b0;
		end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			hold_gap = $urandom_range(0, 3);
			drive_ch.ready <= 1'b0;
		end else begin
			drive_ch.ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor and scoreboard: sample both channels on the rising edge. Check
	// each result transfer against the oldest prediction, then predict for a
	// sensor transfer. Samples with sample_valid low predict nothing.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		steer_t want;
		cycle_count++;
		if (arst_n && drive_ch.valid && drive_ch.ready) begin
			if (steer_q.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("[%0t] unexpected result: drive %0d error %0d", $realtime,
						drive_ch.steering_drive, drive_ch.line_error);
			end else begin
				want = steer_q.pop_front();
				if (drive_ch.steering_drive !== want.drive
						|| drive_ch.line_error !== want.err) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("[%0t] mismatch: drive exp %0d got %0d, error exp %0d got %0d",
							$realtime, want.drive, drive_ch.steering_drive,
							want.err, drive_ch.line_error);
				end
			end
		end
		if (arst_n && sensor_ch.valid && sensor_ch.ready) begin
			sample_live = 1'b0;
			if (sensor_ch.sample_valid)
				steer_q.push_back(advance_steering(sensor_ch.sensor_pattern));
		end
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Register access: one write per call, mirrored into the local copy with
	// the same field masking the core applies.
	// ------------------------------------------------------------------------
	task automatic write_reg(cfg_idx_t idx, logic [CFG_DAT_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_PROP_GAIN:      tuning.kp   = value[KP_W-1:0];
			CFG_DERIV_GAIN:     tuning.kd   = value[KD_W-1:0];
			CFG_INTEGRAL_LIMIT: tuning.ilim = value[ILIM_W-1:0];
			CFG_OUTPUT_LIMIT:   tuning.olim = value[OLIM_W-1:0];
			default: ;
		endcase
	endtask

	// Wait until every sample is transferred and every result checked, then
	// let dropped samples drain out of the pipeline.
	task automatic wait_idle();
		while (sample_q.size() > 0 || sample_live || steer_q.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic queue_sample(logic [7:0] pat, logic good);
		sample_t s;
		s.pattern = pat;
		s.good    = good;
		sample_q.push_back(s);
	endtask

	// Favor zero, all ones and small values so clamps actually engage.
	function automatic logic [CFG_DAT_W-1:0] pick_setting(int unsigned w);
		logic [CFG_DAT_W-1:0] full;
		full = CFG_DAT_W'((1 << w) - 1);
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return full;
			2, 3:    return CFG_DAT_W'($urandom_range(0, 40));
			default: return CFG_DAT_W'($urandom) & full;
		endcase
	endfunction

	// Mostly decoder-relevant patterns in repeated runs, so the integral
	// walks into its clamp; the rest random noise and dropped samples.
	task automatic queue_random(int unsigned good_wanted);
		int unsigned good_seen;
		int unsigned reps;
		logic [7:0]  pat;
		logic        good;
		good_seen = 0;
		while (good_seen < good_wanted) begin
			if ($urandom_range(0, 9) < 3)
				pat = 8'($urandom_range(0, 255));
			else
				pat = FEATURED[$urandom_range(0, 15)];
			reps = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 1;
			repeat (reps) begin
				good = ($urandom_range(0, 9) != 0);
				queue_sample(pat, good);
				if (good)
					good_seen++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		int unsigned phase;

		// Drive every input to a known value from time zero.
		arst_n                   = 1'b0;
		cfg_we                   = 1'b0;
		cfg_index                = CFG_PROP_GAIN;
		cfg_wdata                = '0;
		sensor_ch.valid          = 1'b0;
		sensor_ch.sensor_pattern = '0;
		sensor_ch.sample_valid   = 1'b0;
		drive_ch.ready           = 1'b0;
		sample_live              = 1'b0;
		feed_gap                 = 0;
		hold_gap                 = 0;
		cycle_count              = 0;
		fail_count               = 0;
		idle_odds                = 6;
		tuning.kp                = KP_RESET;
		tuning.kd                = KD_RESET;
		tuning.ilim              = ILIM_RESET;
		tuning.olim              = OLIM_RESET;
		last_err                 = '0;
		integ_sum                = '0;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, reset gains: every decode branch, keep-last on no line,
		// a dropped sample, then a run of hard-right errors to build integral.
		queue_sample(8'hFF, 1'b1);
		queue_sample(8'hEF, 1'b1);
		queue_sample(8'hF7, 1'b1);
		queue_sample(8'hE7, 1'b1);
		queue_sample(8'hDF, 1'b1);
		queue_sample(8'h9F, 1'b1);
		queue_sample(8'hFB, 1'b1);
		queue_sample(8'hF9, 1'b1);
		queue_sample(8'h7F, 1'b1);
		queue_sample(8'h5F, 1'b1);
		queue_sample(8'hBF, 1'b1);
		queue_sample(8'hFD, 1'b1);
		queue_sample(8'hFE, 1'b1);
		queue_sample(8'hEF, 1'b0);
		queue_sample(8'h00, 1'b1);
		repeat (5) queue_sample(8'hFD, 1'b1);
		wait_idle();

		// Lower the integral limit below the stored sum; next step must clamp.
		write_reg(CFG_INTEGRAL_LIMIT, CFG_DAT_W'(3));
		queue_sample(8'hFD, 1'b1);
		queue_sample(8'hDF, 1'b1);
		wait_idle();

		// Zero limits force both integral and drive to zero.
		write_reg(CFG_INTEGRAL_LIMIT, '0);
		write_reg(CFG_OUTPUT_LIMIT, '0);
		queue_sample(8'hFD, 1'b1);
		queue_sample(8'h9F, 1'b1);
		wait_idle();

		// Random phases: all-ones writes (masked to each field), all zeros,
		// then mixed settings. The last phase runs with no idling.
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			if (phase == 0) begin
				write_reg(CFG_PROP_GAIN, '1);
				write_reg(CFG_DERIV_GAIN, '1);
				write_reg(CFG_INTEGRAL_LIMIT, '1);
				write_reg(CFG_OUTPUT_LIMIT, '1);
			end else if (phase == 1) begin
				write_reg(CFG_PROP_GAIN, '0);
				write_reg(CFG_DERIV_GAIN, '0);
				write_reg(CFG_INTEGRAL_LIMIT, '0);
				write_reg(CFG_OUTPUT_LIMIT, '0);
			end else begin
				write_reg(CFG_PROP_GAIN, pick_setting(KP_W));
				write_reg(CFG_DERIV_GAIN, pick_setting(KD_W));
				write_reg(CFG_INTEGRAL_LIMIT, pick_setting(ILIM_W));
				write_reg(CFG_OUTPUT_LIMIT, pick_setting(OLIM_W));
			end
			idle_odds = (phase == PHASE_COUNT - 1) ? 0 : $urandom_range(2, 10);
			queue_random(PHASE_GOOD);
			wait_idle();
		end

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
